>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RGA_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RGA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/rga_pkg.sv
package rga_pkg;

    localparam int FRAME_WIDTH_DEF  = 480;
    localparam int FRAME_HEIGHT_DEF = 800;

    localparam int D2_W       = 20;  // squared distance width when inside
    localparam int S_W        = 26;  // sqrt(d2) in Q16
    localparam int Q_W        = 16;  // ratio in Q16
    localparam int SQRT_STEPS = 26;
    localparam int DIV_STEPS  = 16;
    localparam int SQRT_REM_W = 28;
    localparam int RAD_W      = 10;

    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_GLOW_RED   = 3'd3,
        REG_GLOW_GREEN = 3'd4,
        REG_GLOW_BLUE  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [11:0] center_x;
        logic signed [11:0] center_y;
        logic [RAD_W-1:0]   radius;
        logic [7:0]         glow_red;
        logic [7:0]         glow_green;
        logic [7:0]         glow_blue;
    } cfg_t;

    typedef struct packed {
        logic [15:0] color;
        logic        in_glow;
    } pix_t;

endpackage

>>> hdl/radial_glow_additive_rgb565.sv
// Additive radial glow on RGB565 pixels, one pixel word per clock when not stalled.
// Input channel: in_valid / in_stall with pixel_column, pixel_row, old_color.
// Output channel: out_valid / out_stall with new_color and inside_glow.
// Config channel: cfg_valid / cfg_ready, cfg_index selects center_x (0),
// center_y (1), radius (2), glow_red (3), glow_green (4), glow_blue (5);
// cfg_ready is always high. Write registers only while no pixel is in flight.
// Pipeline: 3 distance stages, 26 root stages at one bit each, 16 divide
// stages at one bit each, 4 blend stages, output register. Throughput: one
// word per cycle while no stall holds the pipeline.
// Reset clears all pipeline valid bits and the config registers to zero.
// When out_stall holds a word, the next word lands in a skid register and
// in_stall rises the following cycle; the whole pipeline freezes until the
// skid word moves out, so nothing is lost or repeated.
module radial_glow_additive_rgb565 #(
    parameter int FRAME_WIDTH  = rga_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = rga_pkg::FRAME_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [8:0]  pixel_column,
    input  logic [9:0]  pixel_row,
    input  logic [15:0] old_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] new_color,
    output logic        inside_glow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import rga_pkg::*;

    cfg_t            cfg_reg;
    logic            skid_full_reg;
    logic            out_valid_reg;
    pix_t            out_pix_reg;
    pix_t            skid_pix_reg;

    logic            adv;
    logic            o_load;
    logic            f_vld;
    logic [D2_W-1:0] f_d2;
    pix_t            f_pix;
    logic            s_vld;
    logic [S_W-1:0]  s_root;
    pix_t            s_pix;
    logic            d_vld;
    logic [Q_W-1:0]  d_ratio;
    pix_t            d_pix;
    logic            b_vld;
    pix_t            b_pix;

    assign adv       = !skid_full_reg;
    assign o_load    = !out_valid_reg || !out_stall;
    assign in_stall  = skid_full_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:   cfg_reg.center_x   <= cfg_data;
                REG_CENTER_Y:   cfg_reg.center_y   <= cfg_data;
                REG_RADIUS:     cfg_reg.radius     <= cfg_data[RAD_W-1:0];
                REG_GLOW_RED:   cfg_reg.glow_red   <= cfg_data[7:0];
                REG_GLOW_GREEN: cfg_reg.glow_green <= cfg_data[7:0];
                REG_GLOW_BLUE:  cfg_reg.glow_blue  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    rga_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg_reg),
        .in_vld  (in_valid),
        .col     (pixel_column),
        .row     (pixel_row),
        .color   (old_color),
        .out_vld (f_vld),
        .d2      (f_d2),
        .pix     (f_pix)
    );

    rga_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (f_vld),
        .d2      (f_d2),
        .in_pix  (f_pix),
        .out_vld (s_vld),
        .root    (s_root),
        .out_pix (s_pix)
    );

    rga_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .radius  (cfg_reg.radius),
        .in_vld  (s_vld),
        .root    (s_root),
        .in_pix  (s_pix),
        .out_vld (d_vld),
        .ratio   (d_ratio),
        .out_pix (d_pix)
    );

    rga_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .cfg     (cfg_reg),
        .in_vld  (d_vld),
        .ratio   (d_ratio),
        .in_pix  (d_pix),
        .out_vld (b_vld),
        .out_pix (b_pix)
    );

    // output register plus one skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (o_load)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end
        else if (b_vld)
        begin
            if (o_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (o_load)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (o_load)
            begin
                out_pix_reg <= skid_pix_reg;
            end
        end
        else if (b_vld)
        begin
            if (o_load)
            begin
                out_pix_reg <= b_pix;
            end
            else
            begin
                skid_pix_reg <= b_pix;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_color   = out_pix_reg.color;
    assign inside_glow = out_pix_reg.in_glow;

endmodule

>>> hdl/rga_front.sv
module rga_front #(
    parameter int FRAME_WIDTH  = rga_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = rga_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  rga_pkg::cfg_t            cfg,
    input  logic                     in_vld,
    input  logic [8:0]               col,
    input  logic [9:0]               row,
    input  logic [15:0]              color,
    output logic                     out_vld,
    output logic [rga_pkg::D2_W-1:0] d2,
    output rga_pkg::pix_t            pix
);
    import rga_pkg::*;

    logic               a_vld_reg;
    logic signed [13:0] a_dx_reg;
    logic signed [13:0] a_dy_reg;
    logic               a_frame_reg;
    logic [15:0]        a_color_reg;

    logic               b_vld_reg;
    logic [23:0]        b_dx2_reg;
    logic [23:0]        b_dy2_reg;
    logic [19:0]        b_rr_reg;
    logic               b_live_reg;
    logic [15:0]        b_color_reg;

    logic               c_vld_reg;
    logic [D2_W-1:0]    c_d2_reg;
    pix_t               c_pix_reg;

    logic signed [13:0] pcx;
    logic signed [13:0] dx_next;
    logic signed [13:0] dy_next;
    logic               frame_next;
    logic signed [27:0] dx_sq;
    logic signed [27:0] dy_sq;
    logic [19:0]        rr;
    logic [24:0]        d2_sum;
    logic               inside_next;

    always_comb
    begin
        pcx        = 14'(FRAME_WIDTH - 1) - {{2{cfg.center_y[11]}}, cfg.center_y};
        dx_next    = $signed({5'b0, col}) - pcx;
        dy_next    = $signed({4'b0, row}) - {{2{cfg.center_x[11]}}, cfg.center_x};
        frame_next = ({3'b0, col} < 12'(FRAME_WIDTH)) && ({2'b0, row} < 12'(FRAME_HEIGHT));
        dx_sq      = a_dx_reg * a_dx_reg;
        dy_sq      = a_dy_reg * a_dy_reg;
        rr         = cfg.radius * cfg.radius;
        d2_sum     = {1'b0, b_dx2_reg} + {1'b0, b_dy2_reg};
        inside_next = b_live_reg && (d2_sum < {5'b0, b_rr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg    <= dx_next;
            a_dy_reg    <= dy_next;
            a_frame_reg <= frame_next;
            a_color_reg <= color;
            b_dx2_reg   <= dx_sq[23:0];
            b_dy2_reg   <= dy_sq[23:0];
            b_rr_reg    <= rr;
            b_live_reg  <= a_frame_reg && (cfg.radius != '0);
            b_color_reg <= a_color_reg;
            // only a distance below r*r (< 2^20) goes on to the root
            c_d2_reg          <= inside_next ? d2_sum[D2_W-1:0] : '0;
            c_pix_reg.color   <= b_color_reg;
            c_pix_reg.in_glow <= inside_next;
        end
    end

    assign out_vld = c_vld_reg;
    assign d2      = c_d2_reg;
    assign pix     = c_pix_reg;

endmodule

>>> hdl/rga_sqrt.sv
module rga_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_vld,
    input  logic [rga_pkg::D2_W-1:0] d2,
    input  rga_pkg::pix_t           in_pix,
    output logic                    out_vld,
    output logic [rga_pkg::S_W-1:0] root,
    output rga_pkg::pix_t           out_pix
);
    import rga_pkg::*;

    // root of d2 * 2^32, one result bit per stage
    logic                  vld_reg  [SQRT_STEPS];
    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [S_W-1:0]        root_reg [SQRT_STEPS];
    logic [D2_W-1:0]       src_reg  [SQRT_STEPS];
    pix_t                  pix_reg  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic                  p_vld;
        logic [SQRT_REM_W-1:0] p_rem;
        logic [S_W-1:0]        p_root;
        logic [D2_W-1:0]       p_src;
        pix_t                  p_pix;
        logic [SQRT_REM_W+1:0] rem_sh;
        logic [SQRT_REM_W+1:0] trial;
        logic                  ge;
        logic [SQRT_REM_W+1:0] rem_sub;

        if (k == 0)
        begin : g_first
            assign p_vld  = in_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_src  = d2;
            assign p_pix  = in_pix;
        end
        else
        begin : g_rest
            assign p_vld  = vld_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_src  = src_reg[k-1];
            assign p_pix  = pix_reg[k-1];
        end

        always_comb
        begin
            rem_sh  = {p_rem, p_src[D2_W-1 -: 2]};
            trial   = (SQRT_REM_W+2)'({p_root, 2'b01});
            ge      = rem_sh >= trial;
            rem_sub = rem_sh - trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? rem_sub[SQRT_REM_W-1:0] : rem_sh[SQRT_REM_W-1:0];
                root_reg[k] <= {p_root[S_W-2:0], ge};
                src_reg[k]  <= {p_src[D2_W-3:0], 2'b00};
                pix_reg[k]  <= p_pix;
            end
        end
    end

    assign out_vld = vld_reg[SQRT_STEPS-1];
    assign root    = root_reg[SQRT_STEPS-1];
    assign out_pix = pix_reg[SQRT_STEPS-1];

endmodule

>>> hdl/rga_div.sv
module rga_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [rga_pkg::RAD_W-1:0] radius,
    input  logic                      in_vld,
    input  logic [rga_pkg::S_W-1:0]   root,
    input  rga_pkg::pix_t             in_pix,
    output logic                      out_vld,
    output logic [rga_pkg::Q_W-1:0]   ratio,
    output rga_pkg::pix_t             out_pix
);
    import rga_pkg::*;

    // restoring division, one quotient bit per stage; top bits of root are below radius when radius is nonzero
    logic             vld_reg [DIV_STEPS];
    logic [RAD_W-1:0] rem_reg [DIV_STEPS];
    logic [Q_W-1:0]   q_reg   [DIV_STEPS];
    logic [Q_W-1:0]   dvd_reg [DIV_STEPS];
    pix_t             pix_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic             p_vld;
        logic [RAD_W-1:0] p_rem;
        logic [Q_W-1:0]   p_q;
        logic [Q_W-1:0]   p_dvd;
        pix_t             p_pix;
        logic [RAD_W:0]   rem_sh;
        logic [RAD_W:0]   rem_sub;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign p_vld = in_vld;
            assign p_rem = root[S_W-1:Q_W];
            assign p_q   = '0;
            assign p_dvd = root[Q_W-1:0];
            assign p_pix = in_pix;
        end
        else
        begin : g_rest
            assign p_vld = vld_reg[k-1];
            assign p_rem = rem_reg[k-1];
            assign p_q   = q_reg[k-1];
            assign p_dvd = dvd_reg[k-1];
            assign p_pix = pix_reg[k-1];
        end

        always_comb
        begin
            rem_sh  = {p_rem, p_dvd[Q_W-1]};
            ge      = rem_sh >= {1'b0, radius};
            rem_sub = rem_sh - {1'b0, radius};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= ge ? rem_sub[RAD_W-1:0] : rem_sh[RAD_W-1:0];
                q_reg[k]   <= {p_q[Q_W-2:0], ge};
                dvd_reg[k] <= {p_dvd[Q_W-2:0], 1'b0};
                pix_reg[k] <= p_pix;
            end
        end
    end

    assign out_vld = vld_reg[DIV_STEPS-1];
    assign ratio   = q_reg[DIV_STEPS-1];
    assign out_pix = pix_reg[DIV_STEPS-1];

endmodule

>>> hdl/rga_blend.sv
module rga_blend (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  rga_pkg::cfg_t           cfg,
    input  logic                    in_vld,
    input  logic [rga_pkg::Q_W-1:0] ratio,
    input  rga_pkg::pix_t           in_pix,
    output logic                    out_vld,
    output rga_pkg::pix_t           out_pix
);
    import rga_pkg::*;

    logic        u_vld_reg;
    logic [16:0] u_reg;
    pix_t        u_pix_reg;

    logic        t_vld_reg;
    logic [16:0] t_reg;
    pix_t        t_pix_reg;

    logic        a_vld_reg;
    logic [5:0]  ar_reg;
    logic [5:0]  ag_reg;
    logic [5:0]  ab_reg;
    pix_t        a_pix_reg;

    logic        o_vld_reg;
    pix_t        o_pix_reg;

    logic [33:0] u_sq;
    logic [21:0] pr;
    logic [22:0] pg;
    logic [21:0] pb;
    logic [6:0]  sr;
    logic [6:0]  sg;
    logic [6:0]  sb;
    logic [4:0]  cr;
    logic [5:0]  cg;
    logic [4:0]  cb;

    always_comb
    begin
        u_sq = u_reg * u_reg;
        pr   = t_reg * cfg.glow_red[7:3];
        pg   = t_reg * cfg.glow_green[7:2];
        pb   = t_reg * cfg.glow_blue[7:3];
        sr   = {2'b0, a_pix_reg.color[15:11]} + {1'b0, ar_reg};
        sg   = {1'b0, a_pix_reg.color[10:5]}  + {1'b0, ag_reg};
        sb   = {2'b0, a_pix_reg.color[4:0]}   + {1'b0, ab_reg};
        cr   = (sr > 7'd31) ? 5'd31 : sr[4:0];
        cg   = (sg > 7'd63) ? 6'd63 : sg[5:0];
        cb   = (sb > 7'd31) ? 5'd31 : sb[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            u_vld_reg <= in_vld;
            t_vld_reg <= u_vld_reg;
            a_vld_reg <= t_vld_reg;
            o_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg     <= 17'h10000 - {1'b0, ratio};
            u_pix_reg <= in_pix;
            t_reg     <= u_sq[32:16];
            t_pix_reg <= u_pix_reg;
            ar_reg    <= pr[21:16];
            ag_reg    <= pg[21:16];
            ab_reg    <= pb[21:16];
            a_pix_reg <= t_pix_reg;
            o_pix_reg.in_glow <= a_pix_reg.in_glow;
            o_pix_reg.color   <= a_pix_reg.in_glow ? {cr, cg, cb} : a_pix_reg.color;
        end
    end

    assign out_vld = o_vld_reg;
    assign out_pix = o_pix_reg;

endmodule

>>> hdl/rga_checker.sv
`include "assert_macros.svh"

module rga_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] new_color,
    input logic        inside_glow
);

    // input backpressure only follows a stalled output
    `RGA_ASSERT_NOW(a_stall_cause, in_stall, $past(out_stall), "in_stall without prior out_stall")

    // a released output drains the skid word, clearing in_stall in the next cycle
    `RGA_ASSERT_NEXT(a_stall_clears, in_stall && !out_stall, !in_stall, "in_stall stuck")

    // backpressure only when a word is waiting at the output
    `RGA_ASSERT_NOW(a_stall_has_word, in_stall, out_valid, "in_stall with empty output")

    `RGA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(new_color) && $stable(inside_glow), "stalled word changed")

endmodule

bind radial_glow_additive_rgb565 rga_checker u_rga_checker (.*);

>>> sim/radial_glow_additive_rgb565_tb.sv
`timescale 1ns / 1ps

module radial_glow_additive_rgb565_tb;
    import rga_pkg::*;

    localparam int FRAME_W     = 480;
    localparam int FRAME_H     = 800;
    localparam int PIPE_DEPTH  = 50;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic [15:0] color;
        logic        in_glow;
    } glow_pix_t;

    typedef struct {
        int          stage;
        int          col;
        int          row;
        logic [15:0] color;
        bit          typed;
        logic [15:0] want_color;
        logic        want_inside;
    } pix_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [8:0]  pixel_column;
    logic [9:0]  pixel_row;
    logic [15:0] old_color;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] new_color;
    logic        inside_glow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    // shadow of the block's registers
    logic signed [11:0] sh_center_x;
    logic signed [11:0] sh_center_y;
    logic [9:0]         sh_radius;
    logic [7:0]         sh_red;
    logic [7:0]         sh_green;
    logic [7:0]         sh_blue;

    glow_pix_t pending_pix[$];
    int        errors;
    int        pixels_sent;
    int        pixels_seen;
    int        inside_seen;
    int        cycles;
    int        rx_wait;
    bit        rx_calm;
    bit        tx_calm;

    // 12-bit values: cx, cy, radius, red, green, blue for directed stages 1 and 2
    logic [11:0] stage_cfg[1:2][6] = '{
        '{12'd400, 12'd239, 12'd100, 12'hFF, 12'hFF, 12'hFF},
        '{12'hFCE, 12'd0,   12'd60,  12'h80, 12'h40, 12'h08}
    };

    pix_row_t pix_table[17] = '{
        '{0, 0,   0,    16'h0000, 1, 16'h0000, 1'b0},
        '{0, 479, 799,  16'hFFFF, 1, 16'hFFFF, 1'b0},
        '{0, 511, 1023, 16'hA5A5, 1, 16'hA5A5, 1'b0},
        '{0, 256, 512,  16'h5A5A, 1, 16'h5A5A, 1'b0},
        '{1, 240, 400,  16'h0000, 1, 16'hFFFF, 1'b1},
        '{1, 240, 400,  16'hFFFF, 1, 16'hFFFF, 1'b1},
        '{1, 340, 400,  16'h1234, 1, 16'h1234, 1'b0},
        '{1, 339, 400,  16'h0000, 0, 16'h0000, 1'b0},
        '{1, 240, 301,  16'h0000, 0, 16'h0000, 1'b0},
        '{1, 300, 450,  16'h8410, 0, 16'h0000, 1'b0},
        '{1, 480, 400,  16'h0000, 1, 16'h0000, 1'b0},
        '{1, 200, 380,  16'hF800, 0, 16'h0000, 1'b0},
        '{1, 241, 400,  16'h07E0, 0, 16'h0000, 1'b0},
        '{2, 479, 0,    16'h0000, 0, 16'h0000, 1'b0},
        '{2, 479, 59,   16'h0000, 0, 16'h0000, 1'b0},
        '{2, 479, 60,   16'h4321, 1, 16'h4321, 1'b0},
        '{2, 478, 799,  16'h7BEF, 1, 16'h7BEF, 1'b0}
    };

    radial_glow_additive_rgb565 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .old_color    (old_color),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_color    (new_color),
        .inside_glow  (inside_glow),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned root_q(input longint unsigned v);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= acc + bitv)
            begin
                v   = v - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end
            else
                acc = acc >> 1;
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    function automatic int sat_add(input int base, input longint unsigned t,
                                   input int chan, input int lim);
        int sum;
        sum = base + int'((t * longint'(chan)) >> 16);
        return (sum > lim) ? lim : sum;
    endfunction

    function automatic glow_pix_t glow_blend(input int col, input int row,
                                             input logic [15:0] color);
        glow_pix_t       res;
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned rr;
        longint unsigned ratio;
        longint unsigned u;
        longint unsigned t;
        int              cr;
        int              cg;
        int              cb;
        dx = longint'(col) - (longint'(FRAME_W - 1) - longint'(sh_center_y));
        dy = longint'(row) - longint'(sh_center_x);
        d2 = dx * dx + dy * dy;
        rr = longint'(sh_radius) * longint'(sh_radius);
        res.color   = color;
        res.in_glow = 1'b0;
        if (col < FRAME_W && row < FRAME_H && sh_radius != 0 && d2 < rr)
        begin
            ratio = root_q(d2 << 32) / sh_radius;
            u     = (64'd1 << 16) - ratio;
            t     = (u * u) >> 16;
            cr    = sat_add(color[15:11], t, sh_red[7:3], 31);
            cg    = sat_add(color[10:5], t, sh_green[7:2], 63);
            cb    = sat_add(color[4:0], t, sh_blue[7:3], 31);
            res.color   = {cr[4:0], cg[5:0], cb[4:0]};
            res.in_glow = 1'b1;
        end
        return res;
    endfunction

    // waits until the pipe is empty, then writes all six registers
    task automatic load_glow(input logic [11:0] vals[6]);
        cfg_reg_t idx;
        wait (pending_pix.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        for (int i = 0; i < 6; i++)
        begin
            idx = cfg_reg_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                REG_CENTER_X:   sh_center_x = vals[i];
                REG_CENTER_Y:   sh_center_y = vals[i];
                REG_RADIUS:     sh_radius   = vals[i][9:0];
                REG_GLOW_RED:   sh_red      = vals[i][7:0];
                REG_GLOW_GREEN: sh_green    = vals[i][7:0];
                REG_GLOW_BLUE:  sh_blue     = vals[i][7:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input int col, input int row, input logic [15:0] color,
                              input bit typed, input glow_pix_t want);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        pixel_column <= col[8:0];
        pixel_row    <= row[9:0];
        old_color    <= color;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pix.push_back(typed ? want : glow_blend(col, row, color));
        pixels_sent++;
    endtask

    // receiver: check every accepted word, random stall between words unless rx_calm is set
    always @(posedge clk or negedge rst_n)
    begin
        glow_pix_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                pixels_seen++;
                if (pending_pix.size() == 0)
                begin
                    $display("%0t: unexpected word color=%h inside=%b",
                             $time, new_color, inside_glow);
                    errors++;
                end
                else
                begin
                    want = pending_pix.pop_front();
                    if (inside_glow) inside_seen++;
                    if (new_color !== want.color)
                    begin
                        $display("%0t: new_color expected %h actual %h",
                                 $time, want.color, new_color);
                        errors++;
                    end
                    if (inside_glow !== want.in_glow)
                    begin
                        $display("%0t: inside_glow expected %b actual %b",
                                 $time, want.in_glow, inside_glow);
                        errors++;
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_stall <= (rx_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("radial_glow_additive_rgb565_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [11:0] vals[6];
        int          pcx;
        int          pcy;
        int          span;
        int          col;
        int          row;
        int          stage;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        pixel_column = '0;
        pixel_row    = '0;
        old_color    = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CENTER_X;
        cfg_data     = '0;
        sh_center_x  = '0;
        sh_center_y  = '0;
        sh_radius    = '0;
        sh_red       = '0;
        sh_green     = '0;
        sh_blue      = '0;
        errors       = 0;
        pixels_sent  = 0;
        pixels_seen  = 0;
        inside_seen  = 0;
        cycles       = 0;
        rx_calm      = 1'b0;
        tx_calm      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stage = 0;
        foreach (pix_table[i])
        begin
            if (pix_table[i].stage != stage)
            begin
                stage = pix_table[i].stage;
                in_valid <= 1'b0;
                vals = stage_cfg[stage];
                load_glow(vals);
            end
            send_pixel(pix_table[i].col, pix_table[i].row, pix_table[i].color,
                       pix_table[i].typed, '{pix_table[i].want_color, pix_table[i].want_inside});
        end

        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            for (int i = 0; i < 6; i++)
                vals[i] = 12'($urandom);
            if (p == 0) begin vals[0] = 12'h800; vals[1] = 12'h7FF; end
            if (p == 1) begin vals[0] = 12'h7FF; vals[1] = 12'h800; end
            case (p % 4)
                0: vals[2] = 12'h3FF;
                1: vals[2] = 12'd1;
                default: vals[2] = 12'($urandom_range(2, 300));
            endcase
            if (p == 3) vals[2] = 12'd0;
            if (p == 2) begin vals[3] = 12'hFF; vals[4] = 12'hFF; vals[5] = 12'hFF; end
            if (p == 4) begin vals[3] = 12'h00; vals[4] = 12'h00; vals[5] = 12'h00; end
            // keep most centres near the frame so the glow lands on real pixels
            if (p >= 2 && $urandom_range(0, 3) != 0)
            begin
                vals[0] = 12'($urandom_range(0, 900)) - 12'd50;
                vals[1] = 12'($urandom_range(0, 560)) - 12'd40;
            end
            load_glow(vals);
            rx_calm = (p == 6);
            tx_calm = (p == 6) || (p == 7);
            pcx  = (FRAME_W - 1) - int'(sh_center_y);
            pcy  = int'(sh_center_x);
            span = int'(sh_radius) + 2;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 5 && k == PHASE_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    wait (pending_pix.size() == 0);
                    @(posedge clk);
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    col = pcx + $urandom_range(0, 2 * span) - span;
                    row = pcy + $urandom_range(0, 2 * span) - span;
                    col = (col < 0) ? 0 : (col > 511) ? 511 : col;
                    row = (row < 0) ? 0 : (row > 1023) ? 1023 : row;
                end
                else
                begin
                    col = $urandom_range(0, 511);
                    row = $urandom_range(0, 1023);
                end
                send_pixel(col, row, 16'($urandom), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        wait (pending_pix.size() == 0);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        $display("covered %0d pixels (%0d inside the glow) over %0d register settings",
                 pixels_seen, inside_seen, PHASES + 2);
        if (errors == 0 && pending_pix.size() == 0)
            $display("radial_glow_additive_rgb565_tb passed");
        else
            $display("radial_glow_additive_rgb565_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rga_pkg.sv
hdl/rga_front.sv
hdl/rga_sqrt.sv
hdl/rga_div.sv
hdl/rga_blend.sv
hdl/radial_glow_additive_rgb565.sv
hdl/rga_checker.sv
sim/radial_glow_additive_rgb565_tb.sv
